### design/ttip_pkg.sv
package ttip_pkg;

   localparam int TABLE_POINTS = 32;
   localparam int IDX_W = 5;
   localparam int CODE_W = 10;
   localparam int TENTHS_W = 11;
   localparam int TEMP_W = 14;
   localparam int NUM_W = CODE_W + TEMP_W;
   localparam int STEP_W = 5;

   localparam logic [TEMP_W-1:0] MIN_TEMP_CENTI = 14'd140;
   localparam logic [TEMP_W-1:0] MAX_TEMP_CENTI = 14'd13950;

   typedef struct packed {
      logic [CODE_W-1:0]   code;
      logic [TENTHS_W-1:0] tenths;
   } bpoint_type;

   // Breakpoints: converter code and temperature in tenths of a degree.
   localparam bpoint_type CURVE [TABLE_POINTS] = '{
      '{10'd250, 11'd14},   '{10'd275, 11'd40},   '{10'd300, 11'd64},
      '{10'd325, 11'd88},   '{10'd350, 11'd111},  '{10'd375, 11'd134},
      '{10'd400, 11'd156},  '{10'd425, 11'd178},  '{10'd450, 11'd200},
      '{10'd475, 11'd222},  '{10'd500, 11'd244},  '{10'd525, 11'd267},
      '{10'd550, 11'd290},  '{10'd575, 11'd313},  '{10'd600, 11'd337},
      '{10'd625, 11'd361},  '{10'd650, 11'd387},  '{10'd675, 11'd413},
      '{10'd700, 11'd441},  '{10'd725, 11'd471},  '{10'd750, 11'd502},
      '{10'd775, 11'd537},  '{10'd784, 11'd550},  '{10'd825, 11'd615},
      '{10'd850, 11'd662},  '{10'd875, 11'd715},  '{10'd900, 11'd779},
      '{10'd925, 11'd857},  '{10'd937, 11'd903},  '{10'd950, 11'd960},
      '{10'd975, 11'd1112}, '{10'd1000, 11'd1395}
   };

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_MUL    = 5'b00100,
      ST_DIV    = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

endpackage

### design/ttip_if.sv
interface ttip_req_if;
   logic                            valid;
   logic                            ready;
   logic [ttip_pkg::CODE_W-1:0]     adc_sample;

   modport source (output valid, output adc_sample, input ready);
   modport sink (input valid, input adc_sample, output ready);
endinterface

interface ttip_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [ttip_pkg::TEMP_W-1:0]     temp_centi;
   logic                            in_range;

   modport source (output valid, output temp_centi, output in_range, input ready);
   modport sink (input valid, input temp_centi, input in_range, output ready);
endinterface

### design/ttip_table.sv
module ttip_table (
   input  logic                        clock,
   input  logic [ttip_pkg::IDX_W-1:0]  rd_addr,
   output ttip_pkg::bpoint_type        rd_data
);

   localparam ttip_pkg::bpoint_type ROM_MEM [ttip_pkg::TABLE_POINTS] = ttip_pkg::CURVE;

   ttip_pkg::bpoint_type rd_data_ff;

   always_ff @(posedge clock) begin
      rd_data_ff <= ROM_MEM[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/ttip_div.sv
module ttip_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [ttip_pkg::NUM_W-1:0]     numer,
   input  logic [ttip_pkg::CODE_W-1:0]    denom,
   output logic                           done,
   output logic [ttip_pkg::TEMP_W-1:0]    quot
);

   localparam logic [ttip_pkg::STEP_W-1:0] LAST_STEP = ttip_pkg::STEP_W'(ttip_pkg::NUM_W - 1);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [ttip_pkg::STEP_W-1:0]     step_ff, step_in;
   logic [ttip_pkg::NUM_W-1:0]      num_ff, num_in;
   logic [ttip_pkg::CODE_W-1:0]     rem_ff, rem_in;
   logic [ttip_pkg::CODE_W-1:0]     den_ff, den_in;
   logic [ttip_pkg::CODE_W:0]       trial;
   logic                            fits;

   // Restoring division: one quotient bit per cycle, shifted into the
   // numerator register as its bits move out into the remainder.
   always_comb begin
      trial = {rem_ff, num_ff[ttip_pkg::NUM_W-1]};
      fits = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      num_in = num_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         num_in = numer;
         rem_in = '0;
         den_in = denom;
      end else if (busy_ff) begin
         num_in = {num_ff[ttip_pkg::NUM_W-2:0], fits};
         rem_in = fits ? ttip_pkg::CODE_W'(trial - {1'b0, den_ff})
                       : trial[ttip_pkg::CODE_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = num_ff[ttip_pkg::TEMP_W-1:0];

endmodule

### design/thermistor_table_interpolator.sv
// Channel | Direction | Payload                  | Handshake
// req     | in        | adc_sample[9:0]          | valid/ready
// rsp     | out       | temp_centi[13:0], in_range | valid/ready
//
// One word at a time. The breakpoint ROM is read one entry per cycle until the
// bracketing segment is found; then a multiply state and, unless the segment is
// flat or of zero span, a 24-step serial divider whose done flag is registered.
// An out-of-range sample scans every entry in use, ENTRIES capped at the table.
// Reset clears the sequencer and the result valid; the table needs no reset.
// A stalled result stays in its register while the next word is taken.
module thermistor_table_interpolator #(
   parameter int ENTRIES = 32
) (
   input  logic        clock,
   input  logic        reset,
   ttip_req_if.sink    req,
   ttip_rsp_if.source  rsp
);

   localparam int USED = (ENTRIES > ttip_pkg::TABLE_POINTS) ? ttip_pkg::TABLE_POINTS : ENTRIES;
   localparam logic [ttip_pkg::IDX_W-1:0] LAST_IDX = ttip_pkg::IDX_W'(USED - 1);

   ttip_pkg::state_type                state_ff, state_in;
   logic [ttip_pkg::IDX_W-1:0]         idx_ff, idx_in;
   logic                               have_prev_ff, have_prev_in;
   ttip_pkg::bpoint_type               prev_ff, prev_in;
   logic [ttip_pkg::CODE_W-1:0]        x_ff, x_in;
   logic [ttip_pkg::TEMP_W-1:0]        base_ff, base_in;
   logic [ttip_pkg::TEMP_W-1:0]        rise10_ff, rise10_in;
   logic [ttip_pkg::CODE_W-1:0]        dx_ff, dx_in;
   logic [ttip_pkg::CODE_W-1:0]        span_ff, span_in;
   logic [ttip_pkg::TEMP_W-1:0]        res_temp_ff, res_temp_in;
   logic                               res_range_ff, res_range_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [ttip_pkg::TEMP_W-1:0]        rsp_temp_ff, rsp_temp_in;
   logic                               rsp_range_ff, rsp_range_in;

   logic [ttip_pkg::IDX_W-1:0]         rd_addr;
   ttip_pkg::bpoint_type               cur;
   logic [ttip_pkg::TENTHS_W-1:0]      rise;
   logic                               div_start;
   logic                               div_done;
   logic [ttip_pkg::TEMP_W-1:0]        div_quot;
   logic [ttip_pkg::NUM_W-1:0]         product;
   logic                               load_rsp;

   ttip_table u_table (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_data (cur)
   );

   ttip_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (product),
      .denom (span_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign rd_addr = (state_ff == ttip_pkg::ST_SCAN) ? idx_ff + 1'b1 : '0;
   assign rise = (cur.tenths > prev_ff.tenths) ? cur.tenths - prev_ff.tenths : '0;
   assign product = {10'b0, rise10_ff} * {14'b0, dx_ff};
   assign load_rsp = (state_ff == ttip_pkg::ST_FINISH) && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      have_prev_in = have_prev_ff;
      prev_in = prev_ff;
      x_in = x_ff;
      base_in = base_ff;
      rise10_in = rise10_ff;
      dx_in = dx_ff;
      span_in = span_ff;
      res_temp_in = res_temp_ff;
      res_range_in = res_range_ff;
      div_start = 1'b0;
      unique case (state_ff)
         ttip_pkg::ST_IDLE: begin
            if (req.valid) begin
               x_in = req.adc_sample;
               idx_in = '0;
               have_prev_in = 1'b0;
               state_in = ttip_pkg::ST_SCAN;
            end
         end
         ttip_pkg::ST_SCAN: begin
            // cur holds entry idx_ff, prev_ff holds the entry below it.
            if (have_prev_ff && prev_ff.code <= x_ff && x_ff <= cur.code) begin
               base_in = ttip_pkg::TEMP_W'({3'b0, prev_ff.tenths} * 14'd10);
               rise10_in = ttip_pkg::TEMP_W'({3'b0, rise} * 14'd10);
               dx_in = x_ff - prev_ff.code;
               span_in = cur.code - prev_ff.code;
               state_in = ttip_pkg::ST_MUL;
            end else if (idx_ff == LAST_IDX) begin
               res_temp_in = '0;
               res_range_in = 1'b0;
               state_in = ttip_pkg::ST_FINISH;
            end else begin
               prev_in = cur;
               have_prev_in = 1'b1;
               idx_in = idx_ff + 1'b1;
            end
         end
         ttip_pkg::ST_MUL: begin
            // A flat segment or a zero span skips the divide.
            if (span_ff != '0 && rise10_ff != '0) begin
               div_start = 1'b1;
               state_in = ttip_pkg::ST_DIV;
            end else begin
               res_temp_in = base_ff;
               res_range_in = 1'b1;
               state_in = ttip_pkg::ST_FINISH;
            end
         end
         ttip_pkg::ST_DIV: begin
            if (div_done) begin
               res_temp_in = base_ff + div_quot;
               res_range_in = 1'b1;
               state_in = ttip_pkg::ST_FINISH;
            end
         end
         ttip_pkg::ST_FINISH: begin
            if (load_rsp) begin
               state_in = ttip_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ttip_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_temp_in = rsp_temp_ff;
      rsp_range_in = rsp_range_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_temp_in = res_temp_ff;
         rsp_range_in = res_range_ff;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ttip_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff <= idx_in;
      have_prev_ff <= have_prev_in;
      prev_ff <= prev_in;
      x_ff <= x_in;
      base_ff <= base_in;
      rise10_ff <= rise10_in;
      dx_ff <= dx_in;
      span_ff <= span_in;
      res_temp_ff <= res_temp_in;
      res_range_ff <= res_range_in;
      rsp_temp_ff <= rsp_temp_in;
      rsp_range_ff <= rsp_range_in;
   end

   assign req.ready = (state_ff == ttip_pkg::ST_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.temp_centi = rsp_temp_ff;
   assign rsp.in_range = rsp_range_ff;

endmodule

### design/ttip_check.sv
module ttip_check (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [ttip_pkg::TEMP_W-1:0]    rsp_temp_centi,
   input logic                           rsp_in_range
);

   // A stalled result word must hold still.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_temp_centi) && $stable(rsp_in_range))
      else $error("result word changed while stalled");

   a_out_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_range |-> rsp_temp_centi == '0)
      else $error("out-of-range result is not zero");

   a_in_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_in_range |->
         rsp_temp_centi >= ttip_pkg::MIN_TEMP_CENTI && rsp_temp_centi <= ttip_pkg::MAX_TEMP_CENTI)
      else $error("in-range result outside the table span");

   // One word in flight: the input closes right after a word is taken.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken twice in a row");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind thermistor_table_interpolator ttip_check u_ttip_check (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_temp_centi (rsp.temp_centi),
   .rsp_in_range   (rsp.in_range)
);
